@@ rtl/hng_pkg.sv @@
// ----------------------------------------------------------------------------
// hng_pkg
// Shared constants, register codes and types of the heightmap normal generator.
// ----------------------------------------------------------------------------
package hng_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;
  localparam int FracBitsDef  = 14;

  localparam int HgtW   = 8;
  localparam int NormW  = 16;
  localparam int ColW   = 10;
  localparam int RowW   = 12;
  localparam int CfgWW  = 11;
  localparam int CfgHW  = 13;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;
  localparam int QueueDepth = 4;

  // Neighbor samples carried by one job: self, left, right, up, down.
  localparam int NumSmp = 5;
  localparam int SmpW   = NumSmp * HgtW;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_INVERT = 2'd2;

  typedef struct packed {
    logic xb;    // border column: double sx
    logic yb;    // border row: double sy
    logic last;  // final normal caused by its height
  } job_flags_t;

endpackage

@@ rtl/hng_front.sv @@
// ----------------------------------------------------------------------------
// hng_front
// Accepts heights, keeps three lines in a store and gathers the five samples
// of each normal that a height completes.
// ----------------------------------------------------------------------------
module hng_front import hng_pkg::*; #(
  parameter int XW = 10,
  parameter int YW = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [HgtW-1:0]   height_i,
  input  logic [XW:0]       img_width_i,
  input  logic [YW:0]       img_height_i,
  input  logic              restart_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output logic [SmpW-1:0]   job_smp_o,
  output logic [XW-1:0]     job_px_o,
  output logic [YW-1:0]     job_py_o,
  output job_flags_t        job_flags_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int AW = XW + 2;

  logic [HgtW-1:0] line_mem [3 * (2 ** XW)];
  logic [HgtW-1:0] rd_q;
  logic [HgtW-1:0] smp_q [NumSmp];

  logic [1:0]    state_q;
  logic [XW-1:0] x_q, jx_q;
  logic [YW-1:0] y_q, jy_q;
  logic [1:0]    ly_q, jly_q;
  logic [3:0]    mask_q, mask_d, cur_oh, rest;
  logic [2:0]    cnt_q;
  logic          acc, lc, lr;
  logic          prevrow, colm1;
  logic [1:0]    lprev, lprev2, self_line, up_line;
  logic [XW-1:0] px, left_col;
  logic [YW-1:0] py;
  logic [AW-1:0] rd_addr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign lc  = ({1'b0, x_q} == img_width_i - 1'b1);
  assign lr  = ({1'b0, y_q} == img_height_i - 1'b1);
  assign mask_d = {lr && lc, lr && (x_q != '0), (y_q != '0) && lc,
                   (y_q != '0) && (x_q != '0)};

  // Serve jobs lowest first: up-left, up, left, self.
  always_comb begin
    priority if (mask_q[0]) cur_oh = 4'b0001;
    else if (mask_q[1]) cur_oh = 4'b0010;
    else if (mask_q[2]) cur_oh = 4'b0100;
    else cur_oh = 4'b1000;
  end

  assign rest    = mask_q & ~cur_oh;
  assign prevrow = cur_oh[0] || cur_oh[1];
  assign colm1   = cur_oh[0] || cur_oh[2];
  assign px      = colm1 ? jx_q - 1'b1 : jx_q;
  assign py      = prevrow ? jy_q - 1'b1 : jy_q;
  assign lprev   = (jly_q == 2'd0) ? 2'd2 : jly_q - 2'd1;
  assign lprev2  = (jly_q == 2'd0) ? 2'd1 : ((jly_q == 2'd1) ? 2'd2 : 2'd0);
  assign self_line = prevrow ? lprev : jly_q;
  assign left_col  = (px != '0) ? px - 1'b1 : px;

  always_comb begin
    if (prevrow) begin
      up_line = (py != '0) ? lprev2 : lprev;
    end else begin
      up_line = (jy_q != '0) ? lprev : jly_q;
    end
  end

  // Right and down neighbors always sit at the newest column and line.
  always_comb begin
    unique case (cnt_q)
      3'd0:    rd_addr = {self_line, px};
      3'd1:    rd_addr = {self_line, left_col};
      3'd2:    rd_addr = {self_line, jx_q};
      3'd3:    rd_addr = {up_line, px};
      default: rd_addr = {jly_q, px};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_mem[{ly_q, x_q}] <= height_i;
    end
    rd_q <= line_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ && cnt_q != 3'd0) begin
      smp_q[cnt_q - 3'd1] <= rd_q;
    end
    if (acc) begin
      jx_q  <= x_q;
      jy_q  <= y_q;
      jly_q <= ly_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      ly_q    <= '0;
      mask_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (restart_i) begin
        x_q  <= '0;
        y_q  <= '0;
        ly_q <= '0;
      end else if (acc) begin
        if (lc) begin
          x_q <= '0;
          if (lr) begin
            y_q  <= '0;
            ly_q <= '0;
          end else begin
            y_q  <= y_q + 1'b1;
            ly_q <= (ly_q == 2'd2) ? 2'd0 : ly_q + 2'd1;
          end
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            mask_q <= mask_d;
            cnt_q  <= '0;
            if (mask_d != '0) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'(NumSmp)) begin
            state_q <= ST_PUSH;
          end
        end
        default: begin
          if (job_ready_i) begin
            mask_q <= rest;
            cnt_q  <= '0;
            state_q <= (rest == '0) ? ST_IDLE : ST_READ;
          end
        end
      endcase
    end
  end

  assign job_valid_o = (state_q == ST_PUSH);
  assign job_smp_o   = {smp_q[4], smp_q[3], smp_q[2], smp_q[1], smp_q[0]};
  assign job_px_o    = px;
  assign job_py_o    = py;
  assign job_flags_o.xb   = (px == '0) || ({1'b0, px} == img_width_i - 1'b1);
  assign job_flags_o.yb   = (py == '0) || ({1'b0, py} == img_height_i - 1'b1);
  assign job_flags_o.last = (rest == '0);

endmodule

@@ rtl/hng_queue.sv @@
// ----------------------------------------------------------------------------
// hng_queue
// Small register FIFO between the gather front and the normalizer.
// ----------------------------------------------------------------------------
module hng_queue import hng_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] data_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != (PW+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = data_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

@@ rtl/hng_back.sv @@
// ----------------------------------------------------------------------------
// hng_back
// Forms the clamped differences and normalizes (-sx, 2, sy) one result bit
// per iteration in three lanes, then holds the normal in an output register.
// ----------------------------------------------------------------------------
module hng_back import hng_pkg::*; #(
  parameter int XW = 10,
  parameter int YW = 12,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_ready_o,
  input  logic [SmpW-1:0]         job_smp_i,
  input  logic [XW-1:0]           job_px_i,
  input  logic [YW-1:0]           job_py_i,
  input  job_flags_t              job_flags_i,
  input  logic                    invert_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [NormW-1:0] normal_x_o,
  output logic signed [NormW-1:0] normal_y_o,
  output logic signed [NormW-1:0] normal_z_o,
  output logic [ColW-1:0]         column_o,
  output logic [RowW-1:0]         row_o,
  output logic                    last_of_run_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SQR  = 3'd1;
  localparam logic [2:0] B_INIT = 3'd2;
  localparam logic [2:0] B_IT0  = 3'd3;
  localparam logic [2:0] B_IT1  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;
  localparam int VW = 2 * FRAC_BITS + 24;
  localparam int BW = $clog2(FRAC_BITS + 1);
  localparam int NL = 3;

  function automatic logic [NormW-1:0] sat_comp(input logic [FRAC_BITS:0] mag,
                                                input logic neg);
    logic signed [32:0] v;
    v = $signed({1'b0, 32'(mag)});
    if (neg) v = -v;
    if (v > 33'sd32767) return 16'h7fff;
    if (v < -33'sd32768) return 16'h8000;
    return v[NormW-1:0];
  endfunction

  logic [2:0]          state_q;
  logic signed [9:0]   sx_q, sy_q;
  logic [XW-1:0]       px_q;
  logic [YW-1:0]       py_q;
  logic                last_q;
  logic [19:0]         s_q;
  logic [VW-1:0]       sh1_q, sh2_q;
  logic [BW-1:0]       b_q;
  logic [VW-1:0]       x_q [NL];
  logic [VW-1:0]       y_q [NL];
  logic [VW-1:0]       w_q [NL];
  logic [VW-1:0]       t1_q [NL];
  logic [VW-1:0]       t2_q [NL];
  logic [VW-1:0]       r_q [NL];
  logic [FRAC_BITS:0]  n_q [NL];
  logic                neg_q [NL];
  logic                out_valid_q;

  logic signed [9:0]  dx, dy;
  logic signed [19:0] sqx, sqy;
  logic [9:0]         magx, magy;
  logic [17:0]        m2x, m2y;
  logic [VW-1:0]      v_sum [NL];
  logic               take [NL];
  logic               out_load;

  assign dx = $signed({2'b00, job_smp_i[23:16]}) - $signed({2'b00, job_smp_i[15:8]});
  assign dy = $signed({2'b00, job_smp_i[39:32]}) - $signed({2'b00, job_smp_i[31:24]});
  assign sqx  = sx_q * sx_q;
  assign sqy  = sy_q * sy_q;
  assign magx = sx_q[9] ? 10'(-sx_q) : 10'(sx_q);
  assign magy = sy_q[9] ? 10'(-sy_q) : 10'(sy_q);
  assign m2x  = magx * magx;
  assign m2y  = magy * magy;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      v_sum[l] = t1_q[l] + t2_q[l];
      take[l]  = !n_q[l][FRAC_BITS] && (v_sum[l] <= r_q[l]);
    end
  end

  assign job_ready_o = (state_q == B_IDLE);
  assign out_load = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        sx_q   <= job_flags_i.xb ? dx <<< 1 : dx;
        sy_q   <= job_flags_i.yb ? dy <<< 1 : dy;
        px_q   <= job_px_i;
        py_q   <= job_py_i;
        last_q <= job_flags_i.last;
      end
      B_SQR: begin
        s_q      <= 20'(sqx) + 20'(sqy) + 20'd4;
        r_q[0]   <= VW'(m2x) << (2 * FRAC_BITS + 2);
        r_q[1]   <= VW'(4) << (2 * FRAC_BITS + 2);
        r_q[2]   <= VW'(m2y) << (2 * FRAC_BITS + 2);
        neg_q[0] <= (sx_q > 10'sd0);
        neg_q[1] <= 1'b0;
        neg_q[2] <= sy_q[9];
      end
      B_INIT: begin
        sh1_q <= VW'(s_q) << (FRAC_BITS + 1);
        sh2_q <= VW'(s_q) << (2 * FRAC_BITS + 2);
        b_q   <= BW'(FRAC_BITS);
        for (int l = 0; l < NL; l++) begin
          x_q[l] <= '0;
          y_q[l] <= '0;
          w_q[l] <= '0;
          n_q[l] <= '0;
        end
      end
      B_IT0: begin
        for (int l = 0; l < NL; l++) begin
          t1_q[l] <= x_q[l] - (y_q[l] << 1) + VW'(s_q) - (sh1_q << 1);
          t2_q[l] <= w_q[l] + sh2_q;
        end
      end
      B_IT1: begin
        // Keep the candidate bit where (2n-1)^2 * s stays within the target.
        for (int l = 0; l < NL; l++) begin
          if (take[l]) begin
            x_q[l]      <= x_q[l] + t2_q[l];
            y_q[l]      <= y_q[l] + sh1_q;
            w_q[l]      <= (w_q[l] + (sh2_q << 1)) >> 1;
            n_q[l][b_q] <= 1'b1;
          end else begin
            w_q[l] <= w_q[l] >> 1;
          end
        end
        sh1_q <= sh1_q >> 1;
        sh2_q <= sh2_q >> 2;
        b_q   <= b_q - 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      normal_x_o    <= sat_comp(n_q[0], neg_q[0] ^ invert_i);
      normal_y_o    <= sat_comp(n_q[1], neg_q[1] ^ invert_i);
      normal_z_o    <= sat_comp(n_q[2], neg_q[2] ^ invert_i);
      column_o      <= ColW'(px_q);
      row_o         <= RowW'(py_q);
      last_of_run_o <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: if (job_valid_i) state_q <= B_SQR;
        B_SQR:  state_q <= B_INIT;
        B_INIT: state_q <= B_IT0;
        B_IT0:  state_q <= B_IT1;
        B_IT1:  state_q <= (b_q == '0) ? B_DONE : B_IT0;
        B_DONE: if (out_load) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/heightmap_normal_generator.sv @@
// ----------------------------------------------------------------------------
// heightmap_normal_generator
// Streams 8-bit heights in raster order and emits one unit normal per pixel.
// ----------------------------------------------------------------------------
// Heights enter one per handshake in raster order; each normal leaves once its
// right and lower neighbors have arrived, so output trails input by about one
// row. A normal is (-sx, 2, sy) scaled to unit length in signed Q1.FRAC_BITS,
// with sx = right - left and sy = below - above, a missing neighbor replaced by
// the pixel itself and the difference doubled on border columns and rows;
// invert negates the whole vector. Each height holds the input side for every
// normal it completes (none in the first row or column, one elsewhere, two at
// the end of a row or along the last row, four at the last pixel): five
// neighbor reads through the single registered read port of the three-line
// store, then a push into a four-entry queue. The normalizer behind the queue
// finds one result bit per iteration in three parallel lanes and takes no new
// normal until the last one is in its output register. That register lets
// the normalizer start the next normal while a finished one waits. Registers:
// image_width at 0x0, image_height at 0x4 (both clamped to [2, MAX]; a write
// restarts the frame at column 0, row 0), invert at 0x8. Write them only while
// the block is idle. The line store has no reset and is read only where the
// current frame has written it.
module heightmap_normal_generator import hng_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [HgtW-1:0]         height_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [NormW-1:0] normal_x_o,
  output logic signed [NormW-1:0] normal_y_o,
  output logic signed [NormW-1:0] normal_z_o,
  output logic [ColW-1:0]         column_o,
  output logic [RowW-1:0]         row_o,
  output logic                    last_of_run_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int QW = SmpW + XW + YW + $bits(job_flags_t);

  // Configuration registers hold the clamped values.
  logic [XW:0]      width_q;
  logic [YW:0]      height_q;
  logic             invert_q;
  logic             cfg_wr, restart;
  logic [1:0]       reg_idx;
  logic [CfgWW-1:0] wr_w;
  logic [CfgHW-1:0] wr_h;

  logic            f_valid, f_ready, b_valid, b_ready;
  logic [SmpW-1:0] f_smp, b_smp;
  logic [XW-1:0]   f_px, b_px;
  logic [YW-1:0]   f_py, b_py;
  job_flags_t      f_flags, b_flags;
  logic [QW-1:0]   q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);
  assign wr_w    = pwdata[CfgWW-1:0];
  assign wr_h    = pwdata[CfgHW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= (XW+1)'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
      height_q <= (YW+1)'(MAX_HEIGHT < 4096 ? MAX_HEIGHT : 4096);
      invert_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH: begin
          if (wr_w < CfgWW'(2)) width_q <= (XW+1)'(2);
          else if (32'(wr_w) > MAX_WIDTH) width_q <= (XW+1)'(MAX_WIDTH);
          else width_q <= (XW+1)'(wr_w);
        end
        REG_HEIGHT: begin
          if (wr_h < CfgHW'(2)) height_q <= (YW+1)'(2);
          else if (32'(wr_h) > MAX_HEIGHT) height_q <= (YW+1)'(MAX_HEIGHT);
          else height_q <= (YW+1)'(wr_h);
        end
        REG_INVERT: invert_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = DataW'(width_q);
      REG_HEIGHT: prdata = DataW'(height_q);
      REG_INVERT: prdata = DataW'(invert_q);
      default:    prdata = '0;
    endcase
  end

  hng_front #(.XW(XW), .YW(YW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .height_i     (height_i),
    .img_width_i  (width_q),
    .img_height_i (height_q),
    .restart_i    (restart),
    .job_valid_o  (f_valid),
    .job_ready_i  (f_ready),
    .job_smp_o    (f_smp),
    .job_px_o     (f_px),
    .job_py_o     (f_py),
    .job_flags_o  (f_flags)
  );

  assign q_wdata = {f_smp, f_px, f_py, f_flags};
  assign {b_smp, b_px, b_py, b_flags} = q_rdata;

  hng_queue #(.DW(QW), .DEPTH(QueueDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (q_wdata),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (q_rdata)
  );

  hng_back #(.XW(XW), .YW(YW), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (b_valid),
    .job_ready_o   (b_ready),
    .job_smp_i     (b_smp),
    .job_px_i      (b_px),
    .job_py_i      (b_py),
    .job_flags_i   (b_flags),
    .invert_i      (invert_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .normal_z_o    (normal_z_o),
    .column_o      (column_o),
    .row_o         (row_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

@@ rtl/hng_checker.sv @@
// ----------------------------------------------------------------------------
// hng_checker
// Port-level checks of the heightmap normal generator, bound to the top level.
// ----------------------------------------------------------------------------
module hng_checker import hng_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [NormW-1:0] normal_x_o,
  input logic signed [NormW-1:0] normal_y_o,
  input logic signed [NormW-1:0] normal_z_o,
  input logic [ColW-1:0]         column_o,
  input logic [RowW-1:0]         row_o,
  input logic                    last_of_run_o
);

  // No result survives reset.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o)
      && $stable(normal_y_o) && $stable(normal_z_o) && $stable(column_o)
      && $stable(row_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // The fixed y term of 2 always leaves a nonzero y component.
  a_y_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> normal_y_o != '0)
    else $error("normal y component is zero");

  // An input taken with a result waiting must not drop that result.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=> out_valid_o)
    else $error("waiting result lost");

endmodule

bind heightmap_normal_generator hng_checker u_hng_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Heightmap normal generator testbench
// Streams height maps through the block, predicts each normal from a local line
// store and an exact integer normalizer, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import hng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LineLen    = MaxWidthDef;
  localparam int DrainWait  = 200;      // covers queued normals of a no-result item
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
    logic [ColW-1:0]         col;
    logic [RowW-1:0]         row;
    logic                    last;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [HgtW-1:0] height_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [NormW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic [ColW-1:0] column_o;
  logic [RowW-1:0] row_o;
  logic last_of_run_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  heightmap_normal_generator i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .height_i,
    .out_valid_o, .out_ready_i, .normal_x_o, .normal_y_o, .normal_z_o,
    .column_o, .row_o, .last_of_run_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: three height lines, raster position and registers.
  logic [HgtW-1:0] line_mem [3*LineLen];
  int unsigned     col_pos, row_pos;
  int unsigned     map_w = 1024, map_h = 4096;
  bit              neg_all;
  normal_t         normals_due [$];

  int  mismatches;
  bit  calm;        // no idling on either side
  int  cycles;

  // Exact round(v * 2^14 / sqrt(s)), ties away from zero, by bitwise search.
  function automatic logic signed [NormW-1:0] unit_scale(int v, longint unsigned s);
    longint unsigned mag, t, n, c, d;
    longint signed   r;
    mag = (v < 0) ? -v : v;
    t = (2 * mag) << FracBitsDef;
    n = 0;
    for (int b = FracBitsDef; b >= 0; b--) begin
      c = n | (64'd1 << b);
      if (c <= (64'd1 << FracBitsDef)) begin
        d = 2 * c - 1;
        if (d * d * s <= t * t) n = c;
      end
    end
    r = (v < 0) ? -longint'(n) : longint'(n);
    if (neg_all) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[NormW-1:0];
  endfunction

  function automatic int height_at(int unsigned x, int unsigned y);
    return line_mem[(y % 3) * LineLen + (x % LineLen)];
  endfunction

  function automatic void add_normal(int unsigned x, int unsigned y);
    int self_h, lf, rt, up, dn, sx, sy;
    longint unsigned s;
    normal_t n;
    self_h = height_at(x, y);
    lf = (x > 0) ? height_at(x - 1, y) : self_h;
    rt = (x < map_w - 1) ? height_at(x + 1, y) : self_h;
    up = (y > 0) ? height_at(x, y - 1) : self_h;
    dn = (y < map_h - 1) ? height_at(x, y + 1) : self_h;
    sx = rt - lf;
    sy = dn - up;
    if (x == 0 || x == map_w - 1) sx *= 2;
    if (y == 0 || y == map_h - 1) sy *= 2;
    s = longint'(sx * sx) + 4 + longint'(sy * sy);
    n.nx = unit_scale(-sx, s);
    n.ny = unit_scale(2, s);
    n.nz = unit_scale(sy, s);
    n.col = x[ColW-1:0];
    n.row = y[RowW-1:0];
    n.last = 1'b0;
    normals_due.push_back(n);
  endfunction

  function automatic void predict_height(logic [HgtW-1:0] h);
    int unsigned x, y, prior_cnt;
    bit lc, lr;
    x = col_pos;
    y = row_pos;
    lc = (x == map_w - 1);
    lr = (y == map_h - 1);
    prior_cnt = normals_due.size();
    line_mem[(y % 3) * LineLen + (x % LineLen)] = h;
    if (y > 0 && x > 0) add_normal(x - 1, y - 1);
    if (y > 0 && lc) add_normal(x, y - 1);
    if (lr && x > 0) add_normal(x - 1, y);
    if (lr && lc) add_normal(x, y);
    if (normals_due.size() > prior_cnt) normals_due[$].last = 1'b1;
    if (lc) begin
      col_pos = 0;
      row_pos = lr ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // Hold valid across back-to-back items; drop it only for an idle burst.
  task automatic send_height(logic [HgtW-1:0] h);
    @(negedge clk_i);
    if (!calm && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    height_i   <= h;
    do @(posedge clk_i); while (!in_ready_o);
    predict_height(h);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Wait for every normal, then let in-flight work finish.
  task automatic settle();
    stop_sending();
    wait (normals_due.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin
        map_w = (val[CfgWW-1:0] < 2) ? 2 : ((val[CfgWW-1:0] > MaxWidthDef) ?
                MaxWidthDef : val[CfgWW-1:0]);
        col_pos = 0; row_pos = 0;
      end
      REG_HEIGHT: begin
        map_h = (val[CfgHW-1:0] < 2) ? 2 : ((val[CfgHW-1:0] > MaxHeightDef) ?
                MaxHeightDef : val[CfgHW-1:0]);
        col_pos = 0; row_pos = 0;
      end
      REG_INVERT: neg_all = val[0];
      default: ;
    endcase
  endtask

  task automatic read_reg(logic [1:0] idx, output logic [DataW-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic check_reg(logic [1:0] idx, logic [DataW-1:0] got,
                           logic [DataW-1:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d mismatch: exp %0d got %0d", idx, want, got);
    end
  endtask

  task automatic send_frame(bit rnd, logic [HgtW-1:0] fill);
    for (int i = 0; i < map_w * map_h; i++)
      send_height(rnd ? $urandom_range(255) : fill);
  endtask

  // Smallest map, flat and steepest slopes, both clamp-below writes.
  task automatic test_min_map();
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_INVERT, 0);
    send_height(8'd0);   send_height(8'd255); send_height(8'd255); send_height(8'd0);
    send_height(8'd255); send_height(8'd0);   send_height(8'd0);   send_height(8'd255);
    send_frame(0, 8'd77);
    settle();
  endtask

  // Negated normals on a 3x3 map with extreme neighbors.
  task automatic test_invert();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    write_reg(REG_INVERT, 1);
    send_height(8'd0);   send_height(8'd255); send_height(8'd0);
    send_height(8'd255); send_height(8'd128); send_height(8'd255);
    send_height(8'd0);   send_height(8'd255); send_height(8'd0);
    settle();
    write_reg(REG_INVERT, 0);
  endtask

  // Drop a frame part way through; the new size restarts at the origin.
  task automatic test_restart();
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 4);
    repeat (6) send_height($urandom_range(255));
    settle();
    write_reg(REG_WIDTH, 5);
    send_frame(1, 0);
    settle();
  endtask

  // Clamp-above writes read back as the largest map.
  task automatic test_max_size();
    logic [DataW-1:0] rd;
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_HEIGHT, 8191);
    read_reg(REG_WIDTH, rd);
    check_reg(REG_WIDTH, rd, DataW'(MaxWidthDef));
    read_reg(REG_HEIGHT, rd);
    check_reg(REG_HEIGHT, rd, DataW'(MaxHeightDef));
  endtask

  // Random whole frames with random sizes and polarity, some cut short.
  task automatic test_random_frames();
    int sent;
    sent = 0;
    while (sent < 140) begin
      if (sent > 100) calm = 1'b1;
      write_reg(REG_INVERT, $urandom_range(1));
      write_reg(REG_WIDTH, $urandom_range(2, 9));
      write_reg(REG_HEIGHT, $urandom_range(2, 6));
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, map_w * map_h - 1)) begin
          send_height($urandom_range(255));
          sent++;
        end
      end else begin
        send_frame(1, 0);
        sent += map_w * map_h;
      end
      settle();
    end
  endtask

  // Receiver: ready in random stall bursts unless calm.
  int stall_left;
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_ready_i <= rst_ni;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(3) == 0) stall_left = $urandom_range(1, 3);
    end
  end

  // Compare each accepted normal with the oldest prediction.
  always @(posedge clk_i) begin
    normal_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{normal_x_o, normal_y_o, normal_z_o, column_o, row_o, last_of_run_o};
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal: x=%0d y=%0d z=%0d col=%0d row=%0d last=%0b",
                   got.nx, got.ny, got.nz, got.col, got.row, got.last);
      end else begin
        want = normals_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("normal mismatch: exp x=%0d y=%0d z=%0d col=%0d row=%0d last=%0b,",
                     want.nx, want.ny, want.nz, want.col, want.row, want.last,
                     " got x=%0d y=%0d z=%0d col=%0d row=%0d last=%0b",
                     got.nx, got.ny, got.nz, got.col, got.row, got.last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_min_map();
    test_invert();
    test_restart();
    test_max_size();
    test_random_frames();
    stop_sending();
    wait (normals_due.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && normals_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hng_pkg.sv
rtl/hng_front.sv
rtl/hng_queue.sv
rtl/hng_back.sv
rtl/heightmap_normal_generator.sv
rtl/hng_checker.sv
dv/testbench.sv
